/* src/m3i_pkg.sv */
package m3i_pkg;

  // Number of elements in one 3x3 matrix, row-major index r*3+c.
  localparam int NUM_ELEMS = 9;

  // Operand indices for each cofactor term of the adjugate, in row-major order.
  // Entry k gives {p, q, s, t}, and the term is a[p]*a[q] - a[s]*a[t].
  localparam int COF_IDX [NUM_ELEMS][4] = '{
    '{4, 8, 7, 5},
    '{7, 2, 1, 8},
    '{1, 5, 4, 2},
    '{6, 5, 3, 8},
    '{0, 8, 6, 2},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{6, 1, 0, 7},
    '{0, 4, 3, 1}
  };

endpackage

/* src/m3i_front.sv */
module m3i_front import m3i_pkg::*; #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic [3:0]            en_i,
  input  logic                  mode_i,
  input  logic signed [W-1:0]   a_i   [NUM_ELEMS],
  output logic signed [3*W+2:0] det_o,
  output logic signed [2*W:0]   e_o   [NUM_ELEMS]
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic signed [2*W-1:0] prod_q [2*NUM_ELEMS];
  logic signed [W-1:0]   row0_q [3];
  logic signed [W-1:0]   row1_q [3];
  logic                  mode_q [3];
  logic signed [CW-1:0]  cof_q  [NUM_ELEMS];
  logic signed [CW-1:0]  cof2_q [NUM_ELEMS];
  logic signed [CW-1:0]  plo_q  [3];
  logic signed [CW-1:0]  phi_q  [3];
  logic signed [DW-1:0]  det_q;
  logic signed [CW-1:0]  e_q    [NUM_ELEMS];
  logic signed [DW-1:0]  det_d;

  // Stage one: the eighteen element products of the cofactors.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        prod_q[2*k]   <= a_i[COF_IDX[k][0]] * a_i[COF_IDX[k][1]];
        prod_q[2*k+1] <= a_i[COF_IDX[k][2]] * a_i[COF_IDX[k][3]];
      end
      for (int k = 0; k < 3; k++) begin
        row0_q[k] <= a_i[k];
      end
      mode_q[0] <= mode_i;
    end
  end

  // Stage two: exact cofactors.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        cof_q[k] <= CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
      end
      row1_q    <= row0_q;
      mode_q[1] <= mode_q[0];
    end
  end

  // Stage three: determinant partial products, each cofactor split at W bits.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int k = 0; k < 3; k++) begin
        plo_q[k] <= row1_q[k] * $signed({1'b0, cof_q[k*3][W-1:0]});
        phi_q[k] <= row1_q[k] * $signed(cof_q[k*3][CW-1:W]);
      end
      cof2_q    <= cof_q;
      mode_q[2] <= mode_q[1];
    end
  end

  // Stage four: determinant sum and mode selection of the adjugate.
  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + DW'(plo_q[k]) + (DW'(phi_q[k]) <<< W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      det_q <= det_d;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          e_q[r*3+c] <= mode_q[2] ? cof2_q[c*3+r] : cof2_q[r*3+c];
        end
      end
    end
  end

  assign det_o = det_q;
  assign e_o   = e_q;

endmodule

/* src/m3i_lane.sv */
module m3i_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic [W:0]            en_i,
  input  logic signed [2*W:0]   e_i,
  input  logic signed [3*W+2:0] det_i,
  output logic [W-1:0]          res_o,
  output logic                  clip_o
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * F;
  localparam int XW = (NW > DW + W) ? NW : DW + W;

  logic [XW-1:0] rem_q [W];
  logic [DW-1:0] den_q [W];
  logic [W-1:0]  q_q   [W+1];
  logic          neg_q [W+1];
  logic          ovf_q [W+1];

  logic [CW-1:0] eabs;
  logic [DW-1:0] dabs;
  logic [XW-1:0] numx;
  logic          ovf;

  // Magnitudes, scaled numerator and the check for a quotient of more than W bits.
  always_comb begin
    eabs = e_i[CW-1] ? CW'(-e_i) : CW'(e_i);
    dabs = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
    numx = XW'(eabs) << (2 * F);
    ovf  = numx >= (XW'(dabs) << W);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= numx;
      den_q[0] <= dabs;
      q_q[0]   <= '0;
      neg_q[0] <= e_i[CW-1] ^ det_i[DW-1];
      ovf_q[0] <= ovf;
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int J = W - s;
    logic [XW-1:0] trial;
    logic          ge;

    assign trial = XW'(den_q[s-1]) << J;
    assign ge    = rem_q[s-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        q_q[s]   <= q_q[s-1] | (ge ? (W'(1) << J) : '0);
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end

    if (s < W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s] <= ge ? rem_q[s-1] - trial : rem_q[s-1];
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    logic [W-1:0] half;
    half   = W'(1) << (W - 1);
    clip_o = 1'b0;
    if (ovf_q[W]) begin
      clip_o = 1'b1;
      res_o  = neg_q[W] ? half : ~half;
    end else if (neg_q[W]) begin
      if (q_q[W] > half) begin
        clip_o = 1'b1;
        res_o  = half;
      end else begin
        res_o = -q_q[W];
      end
    end else if (q_q[W] >= half) begin
      clip_o = 1'b1;
      res_o  = ~half;
    end else begin
      res_o = q_q[W];
    end
  end

endmodule

/* src/matrix3x3_inverse_top.sv */
// 3x3 matrix inverse by adjugate over determinant, signed fixed point with
// FRAC_BITS fraction bits. One item is accepted per clock cycle while
// in_ready_o is high; most of the pipeline stages lie in the nine division
// lanes, each a restoring divider pipeline that retires one quotient bit per
// stage. Cofactors and the determinant are exact; quotients truncate toward
// zero and saturate, with clipped set when any value saturates. A zero
// determinant gives all-zero values with singular set. The pipeline stalls
// stage by stage from the output backward, so empty stages keep filling while
// a finished result waits to be taken.
module matrix3x3_inverse_top import m3i_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic signed [DATA_WIDTH-1:0] a_r1c1_i,
  input  logic signed [DATA_WIDTH-1:0] a_r2c1_i,
  input  logic signed [DATA_WIDTH-1:0] a_r3c1_i,
  input  logic signed [DATA_WIDTH-1:0] a_r1c2_i,
  input  logic signed [DATA_WIDTH-1:0] a_r2c2_i,
  input  logic signed [DATA_WIDTH-1:0] a_r3c2_i,
  input  logic signed [DATA_WIDTH-1:0] a_r1c3_i,
  input  logic signed [DATA_WIDTH-1:0] a_r2c3_i,
  input  logic signed [DATA_WIDTH-1:0] a_r3c3_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] b_r1c1_o,
  output logic signed [DATA_WIDTH-1:0] b_r2c1_o,
  output logic signed [DATA_WIDTH-1:0] b_r3c1_o,
  output logic signed [DATA_WIDTH-1:0] b_r1c2_o,
  output logic signed [DATA_WIDTH-1:0] b_r2c2_o,
  output logic signed [DATA_WIDTH-1:0] b_r3c2_o,
  output logic signed [DATA_WIDTH-1:0] b_r1c3_o,
  output logic signed [DATA_WIDTH-1:0] b_r2c3_o,
  output logic signed [DATA_WIDTH-1:0] b_r3c3_o,
  output logic signed [DATA_WIDTH-1:0] det_value_o,
  output logic                         singular_o,
  output logic                         clipped_o
);

  localparam int W   = DATA_WIDTH;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int NST = W + 6;
  localparam int LS  = 4;

  logic [NST-1:0] v_q, v_d;
  logic [NST:0]   en;

  logic signed [W-1:0]  a_in  [NUM_ELEMS];
  logic signed [DW-1:0] det;
  logic signed [CW-1:0] e     [NUM_ELEMS];
  logic [W-1:0]         res   [NUM_ELEMS];
  logic [NUM_ELEMS-1:0] clip;

  logic [W-1:0] dv_q   [W+1];
  logic         dclp_q [W+1];
  logic         sing_q [W+1];
  logic [DW-1:0] dabs, dq;
  logic [W-1:0]  dval;
  logic          dclip;

  logic [W-1:0] b_q [NUM_ELEMS];
  logic [W-1:0] det_out_q;
  logic         sing_out_q;
  logic         clip_out_q;

  // Stall chain: a stage loads when it is empty or the next stage loads.
  always_comb begin
    en[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NST; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];

  // Row-major element order.
  assign a_in[0] = a_r1c1_i;
  assign a_in[1] = a_r1c2_i;
  assign a_in[2] = a_r1c3_i;
  assign a_in[3] = a_r2c1_i;
  assign a_in[4] = a_r2c2_i;
  assign a_in[5] = a_r2c3_i;
  assign a_in[6] = a_r3c1_i;
  assign a_in[7] = a_r3c2_i;
  assign a_in[8] = a_r3c3_i;

  m3i_front #(.W(W)) u_front (
    .clk_i  (clk_i),
    .en_i   (en[3:0]),
    .mode_i (mode_i),
    .a_i    (a_in),
    .det_o  (det),
    .e_o    (e)
  );

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_lane
    m3i_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en[LS +: W+1]),
      .e_i    (e[k]),
      .det_i  (det),
      .res_o  (res[k]),
      .clip_o (clip[k])
    );
  end

  // Determinant output: truncating shift toward zero, then saturation.
  always_comb begin
    logic [DW-1:0] half;
    half  = DW'(1) << (W - 1);
    dabs  = det[DW-1] ? DW'(-det) : DW'(det);
    dq    = dabs >> (2 * FRAC_BITS);
    dclip = 1'b0;
    if (det[DW-1]) begin
      if (dq > half) begin
        dclip = 1'b1;
        dval  = W'(half);
      end else begin
        dval = W'(-dq);
      end
    end else if (dq >= half) begin
      dclip = 1'b1;
      dval  = ~W'(half);
    end else begin
      dval = W'(dq);
    end
  end

  // Determinant side path, matched to the division lanes.
  always_ff @(posedge clk_i) begin
    if (en[LS]) begin
      dv_q[0]   <= dval;
      dclp_q[0] <= dclip;
      sing_q[0] <= (det == '0);
    end
    for (int s = 1; s <= W; s++) begin
      if (en[LS+s]) begin
        dv_q[s]   <= dv_q[s-1];
        dclp_q[s] <= dclp_q[s-1];
        sing_q[s] <= sing_q[s-1];
      end
    end
  end

  // Merge stage: combine the lanes and the determinant into the output item.
  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        b_q[k] <= sing_q[W] ? '0 : res[k];
      end
      det_out_q  <= sing_q[W] ? '0 : dv_q[W];
      sing_out_q <= sing_q[W];
      clip_out_q <= !sing_q[W] && ((|clip) || dclp_q[W]);
    end
  end

  assign b_r1c1_o    = b_q[0];
  assign b_r1c2_o    = b_q[1];
  assign b_r1c3_o    = b_q[2];
  assign b_r2c1_o    = b_q[3];
  assign b_r2c2_o    = b_q[4];
  assign b_r2c3_o    = b_q[5];
  assign b_r3c1_o    = b_q[6];
  assign b_r3c2_o    = b_q[7];
  assign b_r3c3_o    = b_q[8];
  assign det_value_o = det_out_q;
  assign singular_o  = sing_out_q;
  assign clipped_o   = clip_out_q;

endmodule

/* tb/sv/matrix3x3_inverse_top_test.sv */
module matrix3x3_inverse_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int WW = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2 * DW + 20;

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic             mode;
    word_t [8:0]      a;  // column-major: index c*3+r
  } matrix_item_t;

  typedef struct packed {
    word_t [8:0]          b;
    logic signed [DW-1:0] det;
    logic                 singular;
    logic                 clipped;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic signed [DW-1:0] a_i [9];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DW-1:0] b_o [9];
  logic signed [DW-1:0] det_value_o;
  logic singular_o, clipped_o;

  matrix_item_t pending_items[$];
  inverse_t expected_inverses[$];
  int errors = 0;
  bit stimulus_done = 1'b0;
  int idle_cycles = 0;

  initial begin
    for (int k = 0; k < 9; k++) a_i[k] = '0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  matrix3x3_inverse_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i,
    .a_r1c1_i(a_i[0]), .a_r2c1_i(a_i[1]), .a_r3c1_i(a_i[2]),
    .a_r1c2_i(a_i[3]), .a_r2c2_i(a_i[4]), .a_r3c2_i(a_i[5]),
    .a_r1c3_i(a_i[6]), .a_r2c3_i(a_i[7]), .a_r3c3_i(a_i[8]),
    .out_valid_o, .out_ready_i,
    .b_r1c1_o(b_o[0]), .b_r2c1_o(b_o[1]), .b_r3c1_o(b_o[2]),
    .b_r1c2_o(b_o[3]), .b_r2c2_o(b_o[4]), .b_r3c2_o(b_o[5]),
    .b_r1c3_o(b_o[6]), .b_r2c3_o(b_o[7]), .b_r3c3_o(b_o[8]),
    .det_value_o, .singular_o, .clipped_o
  );

  // Saturate a wide value to the output width, flagging any clipping.
  function automatic logic signed [DW-1:0] clamp_to_word(wide_t v, inout logic clip);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DW - 1)) - 1;
    lo = -(wide_t'(1) <<< (DW - 1));
    if (v > hi) begin
      clip = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Adjugate over exact determinant; quotients truncate toward zero.
  function automatic inverse_t invert_matrix(matrix_item_t it);
    wide_t m [3][3];
    wide_t adj [3][3];
    wide_t det, e, q;
    inverse_t res;
    logic clip;
    clip = 1'b0;
    res = '0;
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) m[r][c] = wide_t'(it.a[c*3+r]);
    adj[0][0] = m[1][1]*m[2][2] - m[2][1]*m[1][2];
    adj[1][0] = m[2][0]*m[1][2] - m[1][0]*m[2][2];
    adj[2][0] = m[1][0]*m[2][1] - m[2][0]*m[1][1];
    adj[0][1] = m[2][1]*m[0][2] - m[0][1]*m[2][2];
    adj[1][1] = m[0][0]*m[2][2] - m[2][0]*m[0][2];
    adj[2][1] = m[2][0]*m[0][1] - m[0][0]*m[2][1];
    adj[0][2] = m[0][1]*m[1][2] - m[1][1]*m[0][2];
    adj[1][2] = m[1][0]*m[0][2] - m[0][0]*m[1][2];
    adj[2][2] = m[0][0]*m[1][1] - m[1][0]*m[0][1];
    det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) begin
        e = it.mode ? adj[c][r] : adj[r][c];
        q = (e <<< (2 * FB)) / det;
        res.b[c*3+r] = clamp_to_word(q, clip);
      end
    q = det / (wide_t'(1) <<< (2 * FB));
    res.det = clamp_to_word(q, clip);
    res.clipped = clip;
    return res;
  endfunction

  function automatic logic [DW-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return DW'($signed($urandom_range(0, 8)) - 4) <<< FB;
      3: return DW'($signed($urandom_range(0, 2047)) - 1024) <<< ($urandom_range(0, 14));
      default: return $urandom();
    endcase
  endfunction

  // Directed corners followed by random matrices.
  initial begin
    matrix_item_t it;
    logic signed [DW-1:0] one, max_v, min_v;
    int n;
    one = DW'(1) <<< FB;
    max_v = {1'b0, {(DW-1){1'b1}}};
    min_v = {1'b1, {(DW-1){1'b0}}};
    // Identity in both modes.
    for (int md = 0; md < 2; md++) begin
      it = '0;
      it.mode = md[0];
      it.a[0] = one; it.a[4] = one; it.a[8] = one;
      pending_items.push_back(it);
    end
    // All zeros gives a singular matrix.
    it = '0;
    pending_items.push_back(it);
    // Rank-one matrix: singular with nonzero entries.
    it = '0;
    for (int k = 0; k < 9; k++) it.a[k] = max_v;
    pending_items.push_back(it);
    // Extremes on the diagonal drive saturation both ways.
    for (int md = 0; md < 2; md++) begin
      it = '0;
      it.mode = md[0];
      it.a[0] = max_v; it.a[4] = min_v; it.a[8] = max_v;
      pending_items.push_back(it);
      it = '0;
      it.mode = md[0];
      it.a[0] = 1; it.a[4] = -1; it.a[8] = 1;
      pending_items.push_back(it);
      it = '0;
      it.mode = md[0];
      it.a[0] = min_v; it.a[4] = min_v; it.a[8] = min_v;
      pending_items.push_back(it);
    end
    // Asymmetric matrix where the two modes differ.
    for (int md = 0; md < 2; md++) begin
      it = '0;
      it.mode = md[0];
      it.a[0] = 2*one; it.a[3] = one; it.a[4] = 3*one; it.a[6] = -one;
      it.a[7] = one; it.a[8] = 4*one;
      pending_items.push_back(it);
    end
    // All-ones and alternating bit patterns.
    it = '0;
    it.mode = 1'b1;
    for (int k = 0; k < 9; k++) it.a[k] = (k % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
    pending_items.push_back(it);
    it = '0;
    for (int k = 0; k < 9; k++) it.a[k] = (k % 2) ? 32'h5555_5555 : 32'hFFFF_FFFF;
    pending_items.push_back(it);
    n = 1350 - pending_items.size();
    for (int i = 0; i < n; i++) begin
      it.mode = $urandom_range(0, 1);
      for (int k = 0; k < 9; k++) it.a[k] = random_word();
      // Some exactly singular matrices: duplicated row.
      if ($urandom_range(0, 15) == 0) begin
        it.a[2] = it.a[0]; it.a[5] = it.a[3]; it.a[8] = it.a[6];
      end
      pending_items.push_back(it);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: offers queued items after a random gap each.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_inverses.push_back(invert_matrix(pending_items.pop_front()));
        send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && send_gap == 0) begin
          in_valid_i <= 1'b1;
          mode_i <= pending_items[0].mode;
          for (int k = 0; k < 9; k++) a_i[k] <= pending_items[0].a[k];
        end else begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
          if (pending_items.size() == 0) stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  int recv_gap = 0;
  int hold_off = 0;
  int taken = 0;
  always @(posedge clk_i) begin
    inverse_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        taken++;
        if (expected_inverses.size() == 0) begin
          $error("result with no expectation pending");
          errors++;
        end else begin
          exp_r = expected_inverses.pop_front();
          for (int k = 0; k < 9; k++)
            if (b_o[k] !== exp_r.b[k]) begin
              $error("b element %0d (r%0dc%0d): expected %0d, actual %0d", k,
                     k % 3 + 1, k / 3 + 1, exp_r.b[k], b_o[k]);
              errors++;
            end
          if (det_value_o !== exp_r.det) begin
            $error("det_value: expected %0d, actual %0d", exp_r.det, det_value_o);
            errors++;
          end
          if (singular_o !== exp_r.singular) begin
            $error("singular: expected %0b, actual %0b", exp_r.singular, singular_o);
            errors++;
          end
          if (clipped_o !== exp_r.clipped) begin
            $error("clipped: expected %0b, actual %0b", exp_r.clipped, clipped_o);
            errors++;
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        // One long hold-off so the pipeline fills and backs up the input.
        if (taken == 300) hold_off = 200;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stimulus_done && expected_inverses.size() == 0) begin
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        if (errors == 0 && expected_inverses.size() == 0) begin
          $display("SCOREBOARD CLEAN");
        end else begin
          $display("SCOREBOARD MISMATCH");
        end
        $finish;
      end
    end
  end

endmodule
